/* design/sta_lta_ratio_detector_core_defines.svh */
// Assertion macros shared by the STA/LTA ratio detector RTL.
`ifndef STA_LTA_RATIO_DETECTOR_CORE_DEFINES_SVH
`define STA_LTA_RATIO_DETECTOR_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SLRD_ASSERT_NOW(LABEL, CLK, RSTN, ANTE, CONS, MSG) \
    LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
        else $error(MSG);

// Consequent must hold in the cycle after the antecedent.
`define SLRD_ASSERT_NEXT(LABEL, CLK, RSTN, ANTE, CONS, MSG) \
    LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
        else $error(MSG);

`endif

/* design/slrd_pkg.sv */
// Shared widths, register codes and status types of the STA/LTA ratio detector.
package slrd_pkg;

    localparam int SUM_W      = 40;
    localparam int STA_W      = 9;
    localparam int LTA_W      = 13;
    localparam int RATIO_W    = 32;
    localparam int FRAC_W     = 16;
    localparam int INT_W      = RATIO_W - FRAC_W;
    localparam int PROD_W     = SUM_W + LTA_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int STA_RESET  = 16;
    localparam int LTA_RESET  = 512;

    localparam logic [CFG_IDX_W-1:0] REG_STA_LEN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LTA_LEN = CFG_IDX_W'(1);

    localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
    localparam logic [RATIO_W-1:0] RATIO_SAT = '1;

    typedef struct packed {
        logic long_ok;
        logic short_ok;
    } tap_flags_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic overflow;
    } div_stat_t;

endpackage

/* design/slrd_history.sv */
// Magnitude delay line with a long tap and a short tap and a fill mark for validity.
module slrd_history
    import slrd_pkg::*;
#(
    parameter int DEPTH = 4352,
    parameter int MAG_W = 23,
    parameter int OFF_W = 13
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [MAG_W-1:0] wr_mag,
    input  logic             wr_ok,
    input  logic [OFF_W-1:0] off_long,
    input  logic [OFF_W-1:0] off_short,
    output logic [MAG_W-1:0] long_mag,
    output logic [MAG_W-1:0] short_mag,
    output tap_flags_t       flags
);

    localparam int AW = $clog2(DEPTH);

    logic [MAG_W:0]   mem [DEPTH];
    logic [MAG_W:0]   long_rd_reg;
    logic [MAG_W:0]   short_rd_reg;
    logic [AW-1:0]    wp_reg;
    logic             wrapped_reg;
    logic             long_wr_reg;
    logic             short_wr_reg;
    logic [AW-1:0]    long_addr;
    logic [AW-1:0]    short_addr;

    // Slot that lies off entries behind the write pointer, modulo the depth.
    function automatic logic [AW-1:0] tap_addr(input logic [AW-1:0] wp,
                                              input logic [OFF_W-1:0] off);
        logic [OFF_W:0] d;
        d = (OFF_W+1)'(wp) - (OFF_W+1)'(off);
        if (d[OFF_W])
        begin
            d = d + (OFF_W+1)'(DEPTH);
        end
        return d[AW-1:0];
    endfunction

    assign long_addr  = tap_addr(wp_reg, off_long);
    assign short_addr = tap_addr(wp_reg, off_short);

    // Read-first: a tap at the full depth sees the entry before it is replaced.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            long_rd_reg    <= mem[long_addr];
            short_rd_reg   <= mem[short_addr];
            mem[wp_reg]    <= {wr_ok, wr_mag};
        end
    end

    // Slots below the write pointer, or every slot once it has wrapped, hold data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg       <= '0;
            wrapped_reg  <= 1'b0;
            long_wr_reg  <= 1'b0;
            short_wr_reg <= 1'b0;
        end
        else if (step)
        begin
            long_wr_reg  <= wrapped_reg || (long_addr < wp_reg);
            short_wr_reg <= wrapped_reg || (short_addr < wp_reg);
            if (wp_reg == AW'(DEPTH - 1))
            begin
                wp_reg      <= '0;
                wrapped_reg <= 1'b1;
            end
            else
            begin
                wp_reg <= wp_reg + AW'(1);
            end
        end
    end

    assign long_mag       = long_rd_reg[MAG_W-1:0];
    assign short_mag      = short_rd_reg[MAG_W-1:0];
    assign flags.long_ok  = long_wr_reg & long_rd_reg[MAG_W];
    assign flags.short_ok = short_wr_reg & short_rd_reg[MAG_W];

endmodule

/* design/slrd_mul.sv */
// Two shift-add multipliers that take one multiplier bit per cycle.
module slrd_mul
    import slrd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SUM_W-1:0]  sum_a,
    input  logic [LTA_W-1:0]  mult_a,
    input  logic [SUM_W-1:0]  sum_b,
    input  logic [STA_W-1:0]  mult_b,
    output logic [PROD_W-1:0] prod_a,
    output logic [PROD_W-1:0] prod_b,
    output mul_stat_t         stat
);

    localparam int CW = $clog2(LTA_W + 1);

    logic [PROD_W-1:0] mc_a_reg;
    logic [PROD_W-1:0] mc_b_reg;
    logic [PROD_W-1:0] acc_a_reg;
    logic [PROD_W-1:0] acc_b_reg;
    logic [LTA_W-1:0]  mp_a_reg;
    logic [LTA_W-1:0]  mp_b_reg;
    logic [CW-1:0]     cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mc_a_reg  <= PROD_W'(sum_a);
            mc_b_reg  <= PROD_W'(sum_b);
            mp_a_reg  <= mult_a;
            mp_b_reg  <= LTA_W'(mult_b);
            acc_a_reg <= '0;
            acc_b_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (mp_a_reg[0])
            begin
                acc_a_reg <= acc_a_reg + mc_a_reg;
            end
            if (mp_b_reg[0])
            begin
                acc_b_reg <= acc_b_reg + mc_b_reg;
            end
            mc_a_reg <= mc_a_reg << 1;
            mc_b_reg <= mc_b_reg << 1;
            mp_a_reg <= mp_a_reg >> 1;
            mp_b_reg <= mp_b_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CW'(LTA_W);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign prod_a    = acc_a_reg;
    assign prod_b    = acc_b_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

/* design/slrd_div.sv */
// Restoring divider giving a Q16.16 quotient one bit per cycle, with overflow check.
module slrd_div
    import slrd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [PROD_W-1:0]  num,
    input  logic [PROD_W-1:0]  den,
    output logic [RATIO_W-1:0] quotient,
    output div_stat_t          stat
);

    localparam int CW = $clog2(RATIO_W + 1);

    logic [PROD_W-1:0]  den_reg;
    logic [PROD_W-1:0]  rem_reg;
    logic [RATIO_W-1:0] dvd_reg;
    logic [RATIO_W-1:0] quo_reg;
    logic [CW-1:0]      cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic               ovf_reg;
    logic               ovf_now;
    logic [PROD_W:0]    trial;
    logic [PROD_W:0]    diff;
    logic               fits;

    // The integer part reaches 2^INT_W exactly when the top of the dividend is not below den.
    assign ovf_now = (num >> INT_W) >= den;
    assign trial   = {rem_reg, dvd_reg[RATIO_W-1]};
    assign diff    = trial - {1'b0, den_reg};
    assign fits    = trial >= {1'b0, den_reg};

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            rem_reg <= num >> INT_W;
            dvd_reg <= {num[INT_W-1:0], {FRAC_W{1'b0}}};
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[PROD_W-1:0] : trial[PROD_W-1:0];
            quo_reg <= {quo_reg[RATIO_W-2:0], fits};
            dvd_reg <= dvd_reg << 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ovf_reg  <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CW'(RATIO_W);
            busy_reg <= !ovf_now;
            done_reg <= ovf_now;
            ovf_reg  <= ovf_now;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign quotient      = quo_reg;
    assign stat.busy     = busy_reg;
    assign stat.done     = done_reg;
    assign stat.overflow = ovf_reg;

endmodule

/* design/sta_lta_ratio_detector_core.sv */
// Top level of the STA/LTA ratio detector: control, window sums and output register.
//
// Channel   Direction  Handshake             Word
// input     in         in_valid / in_ready   sample, sample_ok
// output    out        out_valid / out_ready ratio, ratio_saturated
// config    in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// A word that runs the divider passes through the multiplier's 13 steps and then the
// divider's 32 steps (none on overflow) before its result enters the output register;
// no new input word is accepted until then, so words are never overlapped.
// During warm-up or with a zero long sum the multiplier and the divider are skipped.
// The next input word is accepted in the cycle after a result enters the output register.
// Reset takes effect at once: history slots never written read as held, through the
// write pointer's fill mark, so there is no clearing pass.
// A result that cannot enter a full output register waits until that word is taken.
`include "sta_lta_ratio_detector_core_defines.svh"

module sta_lta_ratio_detector_core
    import slrd_pkg::*;
#(
    parameter int MAX_STA     = 256,
    parameter int MAX_LTA     = 4096,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          sample_ok,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [RATIO_W-1:0]            ratio,
    output logic                          ratio_saturated,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data
);

    localparam int MAG_W = SAMPLE_BITS - 1;
    localparam int DEPTH = MAX_STA + MAX_LTA;
    localparam int CNT_W = $clog2(DEPTH + 2);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TAP,
        ST_SUM,
        ST_CHECK,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t             state_reg;
    logic [STA_W-1:0]   sta_reg;
    logic [LTA_W-1:0]   lta_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [MAG_W-1:0]   held_long_reg;
    logic [MAG_W-1:0]   held_short_reg;
    logic [MAG_W-1:0]   held_new_reg;
    logic [SUM_W-1:0]   sum_short_reg;
    logic [SUM_W-1:0]   sum_long_reg;
    logic               gt_s_reg;
    logic [STA_W-1:0]   n_sta_reg;
    logic [LTA_W-1:0]   n_lta_reg;
    logic [RATIO_W-1:0] res_ratio_reg;
    logic               res_sat_reg;
    logic               out_valid_reg;
    logic [RATIO_W-1:0] ratio_reg;
    logic               sat_reg;

    logic               in_accept;
    logic               cfg_accept;
    logic [CNT_W-1:0]   off_long;
    logic [CNT_W-1:0]   off_short;
    logic [CNT_W-1:0]   cap;
    logic [CNT_W-1:0]   count_clamped;
    logic [CNT_W-1:0]   count_next;
    logic [CNT_W-1:0]   lta_gap;
    logic [MAG_W-1:0]   tap_long_mag;
    logic [MAG_W-1:0]   tap_short_mag;
    tap_flags_t         tap_flags;
    logic               mul_start;
    logic               div_start;
    mul_stat_t          mul_stat;
    div_stat_t          div_stat;
    logic [PROD_W-1:0]  num;
    logic [PROD_W-1:0]  den;
    logic [RATIO_W-1:0] quotient;

    // Length registers are stored already clamped to 1..MAX.
    function automatic logic [STA_W-1:0] clamp_sta(input logic [STA_W-1:0] v);
        logic [STA_W-1:0] r;
        if (v == '0)
        begin
            r = STA_W'(1);
        end
        else if (32'(v) > 32'(MAX_STA))
        begin
            r = STA_W'(MAX_STA);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [LTA_W-1:0] clamp_lta(input logic [LTA_W-1:0] v);
        logic [LTA_W-1:0] r;
        if (v == '0)
        begin
            r = LTA_W'(1);
        end
        else if (32'(v) > 32'(MAX_LTA))
        begin
            r = LTA_W'(MAX_LTA);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    // Absolute value; the most negative code saturates to the largest magnitude.
    function automatic logic [MAG_W-1:0] magnitude(input logic [SAMPLE_BITS-1:0] raw);
        logic [SAMPLE_BITS-1:0] neg;
        logic [MAG_W-1:0]       m;
        neg = ~raw + SAMPLE_BITS'(1);
        if (!raw[SAMPLE_BITS-1])
        begin
            m = raw[MAG_W-1:0];
        end
        else if (neg[SAMPLE_BITS-1])
        begin
            m = '1;
        end
        else
        begin
            m = neg[MAG_W-1:0];
        end
        return m;
    endfunction

    // Add the entering magnitude, remove the leaving one, clamp to 0..SUM_MAX.
    function automatic logic [SUM_W-1:0] sum_step(input logic [SUM_W-1:0] sum,
                                                 input logic [MAG_W-1:0] add,
                                                 input logic [MAG_W-1:0] sub);
        logic [SUM_W+1:0] t;
        logic [SUM_W-1:0] r;
        t = (SUM_W+2)'(sum) + (SUM_W+2)'(add) - (SUM_W+2)'(sub);
        if (t[SUM_W+1])
        begin
            r = '0;
        end
        else if (t[SUM_W])
        begin
            r = SUM_MAX;
        end
        else
        begin
            r = t[SUM_W-1:0];
        end
        return r;
    endfunction

    assign in_ready   = (state_reg == ST_IDLE);
    assign in_accept  = in_valid && in_ready;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;

    // The long tap reaches back over both windows, the short tap over the short one.
    assign off_short = CNT_W'(sta_reg);
    assign off_long  = CNT_W'(sta_reg) + CNT_W'(lta_reg);

    // The sample count saturates one above the combined window length. A length change
    // first pulls an old count down to the new limit.
    assign cap           = off_long + CNT_W'(1);
    assign count_clamped = (count_reg > cap) ? cap : count_reg;
    assign count_next    = (count_clamped < cap) ? count_clamped + CNT_W'(1) : count_clamped;
    assign lta_gap       = count_reg - CNT_W'(sta_reg);

    slrd_history #(
        .DEPTH (DEPTH),
        .MAG_W (MAG_W),
        .OFF_W (CNT_W)
    ) u_history (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (in_accept),
        .wr_mag    (magnitude(sample)),
        .wr_ok     (sample_ok),
        .off_long  (off_long),
        .off_short (off_short),
        .long_mag  (tap_long_mag),
        .short_mag (tap_short_mag),
        .flags     (tap_flags)
    );

    // The short-window numerator is scaled by the long count and vice versa, so the
    // two averages are compared without dividing by either count.
    assign mul_start = (state_reg == ST_CHECK) && gt_s_reg && (sum_long_reg != '0);
    assign div_start = (state_reg == ST_MUL) && mul_stat.done;

    slrd_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .sum_a  (sum_short_reg),
        .mult_a (n_lta_reg),
        .sum_b  (sum_long_reg),
        .mult_b (n_sta_reg),
        .prod_a (num),
        .prod_b (den),
        .stat   (mul_stat)
    );

    slrd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (num),
        .den      (den),
        .quotient (quotient),
        .stat     (div_stat)
    );

    // Window state and length registers. The short tap feeds both the entry into the
    // long window and the exit from the short window, so one held value serves both.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sta_reg        <= clamp_sta(STA_W'(STA_RESET));
            lta_reg        <= clamp_lta(LTA_W'(LTA_RESET));
            count_reg      <= '0;
            held_long_reg  <= '0;
            held_short_reg <= '0;
            held_new_reg   <= '0;
            sum_short_reg  <= '0;
            sum_long_reg   <= '0;
            gt_s_reg       <= 1'b0;
            n_sta_reg      <= '0;
            n_lta_reg      <= '0;
        end
        else
        begin
            if (cfg_accept)
            begin
                unique case (cfg_index)
                    REG_STA_LEN: sta_reg <= clamp_sta(cfg_data[STA_W-1:0]);
                    REG_LTA_LEN: lta_reg <= clamp_lta(cfg_data[LTA_W-1:0]);
                    default: ;
                endcase
            end

            if (in_accept)
            begin
                count_reg <= count_next;
                if (sample_ok)
                begin
                    held_new_reg <= magnitude(sample);
                end
            end

            if (state_reg == ST_TAP)
            begin
                if (tap_flags.long_ok)
                begin
                    held_long_reg <= tap_long_mag;
                end
                if (tap_flags.short_ok)
                begin
                    held_short_reg <= tap_short_mag;
                end
                gt_s_reg  <= count_reg > CNT_W'(sta_reg);
                n_sta_reg <= (count_reg < CNT_W'(sta_reg)) ? STA_W'(count_reg) : sta_reg;
                n_lta_reg <= (lta_gap > CNT_W'(lta_reg)) ? lta_reg : LTA_W'(lta_gap);
            end

            // The long sum only moves once the short window has filled.
            if (state_reg == ST_SUM)
            begin
                sum_short_reg <= sum_step(sum_short_reg, held_new_reg, held_short_reg);
                if (gt_s_reg)
                begin
                    sum_long_reg <= sum_step(sum_long_reg, held_short_reg, held_long_reg);
                end
            end
        end
    end

    // Sequencer and output register. A result is decided in CHECK for warm-up and a
    // zero long sum, otherwise after the divider, and waits in FIN for a free output.
    // In FIN a word taken from the output register is replaced in the same cycle, so
    // the plain clear applies only outside FIN.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_ratio_reg <= '0;
            res_sat_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            ratio_reg     <= '0;
            sat_reg       <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && (state_reg != ST_FIN))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        state_reg <= ST_TAP;
                    end
                end
                ST_TAP:
                begin
                    state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    state_reg <= ST_CHECK;
                end
                ST_CHECK:
                begin
                    if (!gt_s_reg)
                    begin
                        res_ratio_reg <= '0;
                        res_sat_reg   <= 1'b0;
                        state_reg     <= ST_FIN;
                    end
                    else if (sum_long_reg == '0)
                    begin
                        res_ratio_reg <= RATIO_SAT;
                        res_sat_reg   <= 1'b1;
                        state_reg     <= ST_FIN;
                    end
                    else
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    if (mul_stat.done)
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_stat.done)
                    begin
                        res_ratio_reg <= div_stat.overflow ? RATIO_SAT : quotient;
                        res_sat_reg   <= div_stat.overflow;
                        state_reg     <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        ratio_reg     <= res_ratio_reg;
                        sat_reg       <= res_sat_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign ratio           = ratio_reg;
    assign ratio_saturated = sat_reg;

    // The divider only starts on the multiplier's finish, so the two never overlap.
    `SLRD_ASSERT_NOW(a_units_exclusive, clk, rst_n, mul_stat.busy, !div_stat.busy, "multiplier and divider busy together")
    // One word is in flight at a time.
    `SLRD_ASSERT_NEXT(a_one_word_in_flight, clk, rst_n, in_valid && in_ready, !in_ready, "input accepted while a word is in flight")
    // A saturated result always carries the all-ones ratio.
    `SLRD_ASSERT_NOW(a_sat_code, clk, rst_n, out_valid && ratio_saturated, ratio == RATIO_SAT, "saturated word without all-ones ratio")

endmodule
